@@ rtl/core/c1ks_pkg.sv @@
// Types, constants and functions shared by the Crypto1 keystream cipher unit.
// No dependencies.
`timescale 1ns / 1ps

package c1ks_pkg;

  localparam int unsigned HALF_W  = 24;
  localparam int unsigned KEY_W   = 48;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STEP_W  = 5;

  localparam logic [HALF_W-1:0] TAPS_ODD  = 24'h29CE5C;
  localparam logic [HALF_W-1:0] TAPS_EVEN = 24'h870804;

  // Two-level nonlinear filter: five first-level nibble functions feed a
  // 5-to-1 output function.
  localparam logic [19:0] FILT_A = 20'hf22c0;
  localparam logic [19:0] FILT_B = 20'h6c9c0;
  localparam logic [19:0] FILT_C = 20'h3c8b0;
  localparam logic [19:0] FILT_D = 20'h1e458;
  localparam logic [19:0] FILT_E = 20'h0d938;
  localparam logic [31:0] FILT_OUT = 32'hEC57E80A;

  // Word action feeds bytes in ISO 14443A order: bit position = step ^ 24.
  localparam logic [STEP_W-1:0] WORD_SWIZZLE = 5'd24;

  localparam logic [STEP_W-1:0] LAST_BIT  = 5'd0;
  localparam logic [STEP_W-1:0] LAST_BYTE = 5'd7;
  localparam logic [STEP_W-1:0] LAST_WORD = 5'd31;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_BIT  = 2'd1,
    ACT_BYTE = 2'd2,
    ACT_WORD = 2'd3
  } action_t;

  typedef struct packed {
    logic capture;   // take a new transaction from the request channel
    logic step;      // run one LFSR step
    logic push;      // move the result into the output register
    logic key_wr;    // write the key register
  } cmd_t;

  typedef struct packed {
    logic is_load;   // request action is a key load
    logic last_step; // current step is the final one of the action
  } status_t;

  function automatic logic filter_bit(input logic [HALF_W-1:0] v);
    logic [4:0] sel;
    sel[4] = FILT_A[{1'b0, v[3:0]}   + 5'd4];
    sel[3] = FILT_B[{1'b0, v[7:4]}   + 5'd3];
    sel[2] = FILT_C[{1'b0, v[11:8]}  + 5'd2];
    sel[1] = FILT_D[{1'b0, v[15:12]} + 5'd1];
    sel[0] = FILT_E[{1'b0, v[19:16]}];
    return FILT_OUT[sel];
  endfunction

  // Odd half bit (23-k) = key bit ((46-2k)^7), even half bit (23-k) = key bit ((47-2k)^7).
  function automatic logic [2*HALF_W-1:0] key_to_halves(input logic [KEY_W-1:0] key);
    logic [HALF_W-1:0] odd_h;
    logic [HALF_W-1:0] even_h;
    for (int k = 0; k < HALF_W; k++) begin
      odd_h[HALF_W-1-k]  = key[(46 - 2*k) ^ 7];
      even_h[HALF_W-1-k] = key[(47 - 2*k) ^ 7];
    end
    return {odd_h, even_h};
  endfunction

endpackage

@@ rtl/core/c1ks_dp.sv @@
// Datapath of the Crypto1 keystream cipher unit: key register, LFSR halves,
// step counter, keystream accumulator and output register. Uses c1ks_pkg.
`timescale 1ns / 1ps

module c1ks_dp
  import c1ks_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic [KEY_W-1:0]   cipher_key,
  input  logic [1:0]         action,
  input  logic [DATA_W-1:0]  data_in,
  input  logic               feed_keystream,
  output logic [DATA_W-1:0]  keystream
);

  logic [KEY_W-1:0]  key;
  logic [HALF_W-1:0] odd_half;
  logic [HALF_W-1:0] even_half;
  action_t           act;
  logic [DATA_W-1:0] data;
  logic              feed;
  logic [STEP_W-1:0] step_cnt;
  logic [DATA_W-1:0] ks_acc;

  logic [STEP_W-1:0] last_idx;
  logic [STEP_W-1:0] pos;
  logic              ks_bit;
  logic              fb;
  logic [HALF_W-1:0] shifted_even;
  logic [2*HALF_W-1:0] loaded;

  always_comb begin
    case (act)
      ACT_BIT:  last_idx = LAST_BIT;
      ACT_BYTE: last_idx = LAST_BYTE;
      ACT_WORD: last_idx = LAST_WORD;
      default:  last_idx = LAST_BIT;
    endcase
  end

  assign pos    = (act == ACT_WORD) ? (step_cnt ^ WORD_SWIZZLE) : step_cnt;
  assign ks_bit = filter_bit(odd_half);
  assign fb     = ^{(odd_half & TAPS_ODD), (even_half & TAPS_EVEN), data[pos], ks_bit & feed};
  assign shifted_even = {even_half[HALF_W-2:0], fb};
  assign loaded = key_to_halves(key);

  assign sts.is_load   = (action_t'(action) == ACT_LOAD);
  assign sts.last_step = (step_cnt == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      key       <= '0;
      odd_half  <= '0;
      even_half <= '0;
      act       <= ACT_LOAD;
      step_cnt  <= '0;
    end else begin
      if (cmd.key_wr) begin
        key <= cipher_key;
      end
      if (cmd.capture) begin
        act      <= action_t'(action);
        step_cnt <= '0;
        if (sts.is_load) begin
          odd_half  <= loaded[2*HALF_W-1:HALF_W];
          even_half <= loaded[HALF_W-1:0];
        end
      end else if (cmd.step) begin
        // shift feedback into even half, then swap halves
        odd_half  <= shifted_even;
        even_half <= odd_half;
        step_cnt  <= step_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data   <= data_in;
      feed   <= feed_keystream;
      ks_acc <= '0;
    end else if (cmd.step) begin
      ks_acc[pos] <= ks_bit;
    end
    if (cmd.push) begin
      keystream <= ks_acc;
    end
  end

endmodule

@@ rtl/core/c1ks_ctrl.sv @@
// Controller of the Crypto1 keystream cipher unit: accept, step and result
// handoff sequencing plus the output valid flag. Uses c1ks_pkg.
`timescale 1ns / 1ps

module c1ks_ctrl
  import c1ks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.push    = 1'b0;
    cmd.key_wr  = cfg_valid && cfg_ready;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.is_load ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (slot_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_push_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> rsp_valid)
    else $error("result push did not raise rsp_valid");

  a_push_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!rsp_valid || !rsp_stall))
    else $error("result pushed over an untaken result");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && sts.last_step) |=> (state == S_DONE))
    else $error("final step did not lead to result handoff");

  a_load_no_steps: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && sts.is_load) |=> (state == S_DONE && !cmd.step))
    else $error("key load ran LFSR steps");

endmodule

@@ rtl/core/crypto1_keystream_cipher_unit.sv @@
// Top level of the Crypto1 keystream cipher unit: joins controller and datapath.
// Depends on c1ks_pkg, c1ks_ctrl and c1ks_dp.
`timescale 1ns / 1ps

// Crypto1 stream cipher with a 48-bit key register written through the cfg
// channel (write only while no transaction is in flight). A load action puts
// the key into the LFSR; bit, byte and word actions run 1, 8 and 32 LFSR
// steps and return the keystream bits at the positions of the data_in bits
// fed in (word action in ISO 14443A byte order; load returns zero). The
// datapath runs one LFSR step per clock; a load goes from acceptance straight
// to result handoff, a clocking action first runs all of its steps.
// One transaction is worked at a time; the result sits in an output register,
// so the next request is taken while a result still waits on rsp_stall.

module crypto1_keystream_cipher_unit
  import c1ks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KEY_W-1:0]  cipher_key,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        action,
  input  logic [DATA_W-1:0] data_in,
  input  logic              feed_keystream,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [DATA_W-1:0] keystream
);

  cmd_t    cmd;
  status_t sts;

  c1ks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  c1ks_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cipher_key     (cipher_key),
    .action         (action),
    .data_in        (data_in),
    .feed_keystream (feed_keystream),
    .keystream      (keystream)
  );

endmodule
